[rtl/core/rtpfu_pkg.sv]
// Shared types and constants for the RTP H.264 FU-A packetizer.
// Holds the channel payload structs, the per-item packet descriptor and header codes.
// No dependencies.
package rtpfu_pkg;

  localparam int unsigned CHUNK_W = 11;
  localparam int unsigned CHUNK_MAX = (1 << CHUNK_W) - 1;
  localparam int unsigned MAX_CHUNK_LIMIT_DEF = 1500;
  localparam int unsigned MAX_CHUNK_RESET = 1350;
  localparam logic [CHUNK_W-1:0] MIN_CHUNK = CHUNK_W'(2);

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SSRC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SEQ = 2'd2;

  localparam logic [7:0] RTP_VER_BYTE = 8'h80;
  localparam logic [7:0] PT_MARKER = 8'hE1;
  localparam logic [7:0] PT_NO_MARKER = 8'h61;
  localparam logic [7:0] NRI_MASK = 8'hE0;
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [7:0] FU_A_TYPE = 8'd28;
  localparam logic [7:0] FU_START_BIT = 8'h80;
  localparam logic [7:0] FU_END_BIT = 8'h40;

  localparam logic [3:0] RTP_HDR_LEN = 4'd12;
  localparam logic [3:0] FU_HDR_LEN = 4'd14;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_nal;
    logic [15:0] nal_length;
    logic [31:0] rtp_timestamp;
  } rtpfu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
    logic       last_of_item;
  } rtpfu_out_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic [31:0]        ssrc;
    logic               seq_load;
    logic [15:0]        seq_value;
  } rtpfu_cfg_t;

  // Everything the byte sequencer needs to emit the results of one item.
  typedef struct packed {
    logic        hdr_en;
    logic        fu;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic        pay_en;
    logic [7:0]  pay_byte;
    logic        pay_eop;
  } rtpfu_desc_t;

endpackage

[rtl/core/rtp_h264_fu_a_packetizer_unit.sv]
// RTP H.264 packetizer with single-NAL and FU-A fragmentation modes.
//
// Input channel (in_*): one NAL byte per transfer; first_of_nal marks the unit's
// header byte and carries nal_length and rtp_timestamp. Output channel (out_*): one
// RTP packet byte per transfer, end_of_packet on a packet's final byte and
// last_of_item on the final byte caused by an input byte. Configuration (cfg_*):
// index 0 chunk size, 1 SSRC, 2 initial sequence number (also loads the counter);
// writes are always accepted and belong between units of traffic.
//
// The first result of an accepted byte passes through the descriptor stage and then
// the output register. Results leave through the single byte-wide output register;
// a byte that opens a packet yields the RTP header (FU-A adds the FU indicator and
// header) ahead of any payload, and a new input byte is accepted in the cycle the
// previous item's last result moves to the output register.
// Reset (rst_n low, synchronous) empties both stages and clears the unit state and
// sequence counter. When the receiver stalls, the output register holds and the
// descriptor stage fills, after which in_ready drops until bytes drain.
module rtp_h264_fu_a_packetizer_unit #(
  parameter int unsigned MAX_CHUNK_LIMIT = rtpfu_pkg::MAX_CHUNK_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rtpfu_pkg::rtpfu_in_t            in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rtpfu_pkg::rtpfu_out_t           out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtpfu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);
  import rtpfu_pkg::*;

  rtpfu_cfg_t  cfg;
  rtpfu_desc_t desc;
  logic        desc_load;
  logic        in_accept;

  assign in_accept = in_valid && in_ready;

  rtpfu_regs #(
    .MAX_CHUNK_LIMIT(MAX_CHUNK_LIMIT)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rtpfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .cfg       (cfg),
    .desc_load (desc_load),
    .desc      (desc)
  );

  rtpfu_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .desc_load (desc_load),
    .desc      (desc),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A packet can only close on the payload byte, which is always an item's last result.
  a_eop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.end_of_packet || out_data.last_of_item))
    else $error("end_of_packet on a result that is not the item's last");

  // The results of one item leave without gaps once the receiver takes them.
  a_item_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_of_item) |=> out_valid)
    else $error("gap inside the results of one item");

  // A unit's header byte always yields results.
  a_first_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.first_of_nal) |-> desc_load)
    else $error("first byte of a unit produced no descriptor");

endmodule

[rtl/core/rtpfu_regs.sv]
// Configuration register file of the packetizer.
// Stores the clamped chunk size and the SSRC; a sequence write is passed on as a load.
// Depends on rtpfu_pkg.
module rtpfu_regs #(
  parameter int unsigned MAX_CHUNK_LIMIT = rtpfu_pkg::MAX_CHUNK_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rtpfu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output rtpfu_pkg::rtpfu_cfg_t          cfg
);
  import rtpfu_pkg::*;

  localparam int unsigned CHUNK_HI =
    (MAX_CHUNK_LIMIT < CHUNK_MAX) ? MAX_CHUNK_LIMIT : CHUNK_MAX;
  localparam int unsigned CHUNK_RST =
    (MAX_CHUNK_RESET > CHUNK_HI) ? CHUNK_HI : MAX_CHUNK_RESET;

  logic               wr;
  logic [CHUNK_W-1:0] raw_chunk;
  logic [CHUNK_W-1:0] chunk_nxt;
  logic [CHUNK_W-1:0] chunk_r;
  logic [31:0]        ssrc_r;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid && cfg_ready;
  assign raw_chunk = cfg_data[CHUNK_W-1:0];

  // The chunk size is clamped once at write time, so the item path sees a legal value.
  always_comb begin
    if (raw_chunk < MIN_CHUNK) begin
      chunk_nxt = MIN_CHUNK;
    end else if (raw_chunk > CHUNK_W'(CHUNK_HI)) begin
      chunk_nxt = CHUNK_W'(CHUNK_HI);
    end else begin
      chunk_nxt = raw_chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= CHUNK_W'(CHUNK_RST);
      ssrc_r  <= '0;
    end else if (wr) begin
      if (cfg_index == REG_MAX_CHUNK) begin
        chunk_r <= chunk_nxt;
      end
      if (cfg_index == REG_SSRC) begin
        ssrc_r <= cfg_data;
      end
    end
  end

  assign cfg.chunk     = chunk_r;
  assign cfg.ssrc      = ssrc_r;
  assign cfg.seq_load  = wr && (cfg_index == REG_INIT_SEQ);
  assign cfg.seq_value = cfg_data[15:0];

endmodule

[rtl/core/rtpfu_ctrl.sv]
// Per-item decision logic and NAL unit state of the packetizer.
// On each accepted byte it updates the unit state and builds a packet descriptor.
// Depends on rtpfu_pkg.
module rtpfu_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_accept,
  input  rtpfu_pkg::rtpfu_in_t   in_data,
  input  rtpfu_pkg::rtpfu_cfg_t  cfg,
  output logic                   desc_load,
  output rtpfu_pkg::rtpfu_desc_t desc
);
  import rtpfu_pkg::*;

  logic [15:0]        seq_r;
  logic [15:0]        pos_r;
  logic [CHUNK_W-1:0] chunk_r;
  logic [15:0]        total_r;
  logic [7:0]         hdr_r;
  logic [31:0]        ts_r;
  logic               frag_r;

  logic [15:0]        seq_nxt;
  logic [15:0]        pos_nxt;
  logic [CHUNK_W-1:0] chunk_nxt;

  logic               first;
  logic [15:0]        len_fix;
  logic [15:0]        e_total;
  logic [15:0]        e_pos;
  logic [CHUNK_W-1:0] e_chunk;
  logic [7:0]         e_hdr;
  logic [31:0]        e_ts;
  logic               e_frag;
  logic               active;
  logic               unit_end;
  logic               last_chunk;
  logic               chunk_full;
  logic               hdr_en;
  logic               pay_en;
  logic               pay_eop;

  assign first   = in_data.first_of_nal;
  assign len_fix = (in_data.nal_length == 16'd0) ? 16'd1 : in_data.nal_length;

  // A first byte restarts the unit; its values take effect for this same item.
  assign e_total = first ? len_fix : total_r;
  assign e_pos   = first ? 16'd0 : pos_r;
  assign e_chunk = first ? '0 : chunk_r;
  assign e_hdr   = first ? in_data.data_byte : hdr_r;
  assign e_ts    = first ? in_data.rtp_timestamp : ts_r;
  assign e_frag  = first ? (len_fix > 16'(cfg.chunk)) : frag_r;

  assign active     = e_pos < e_total;
  assign unit_end   = (e_pos + 16'd1) == e_total;
  assign last_chunk = (e_total - e_pos) <= 16'(cfg.chunk);
  assign chunk_full = ({1'b0, e_chunk} + 12'd1) >= {1'b0, cfg.chunk};

  assign hdr_en  = active && (e_frag ? (e_chunk == '0) : (e_pos == 16'd0));
  assign pay_en  = active && (!e_frag || (e_pos != 16'd0));
  assign pay_eop = e_frag ? (unit_end || chunk_full) : unit_end;

  always_comb begin
    seq_nxt   = seq_r + 16'(hdr_en);
    pos_nxt   = active ? (e_pos + 16'd1) : pos_r;
    chunk_nxt = e_chunk;
    if (active && e_frag) begin
      chunk_nxt = pay_eop ? '0 : (e_chunk + CHUNK_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= '0;
      pos_r   <= '0;
      chunk_r <= '0;
      total_r <= '0;
      hdr_r   <= '0;
      ts_r    <= '0;
      frag_r  <= 1'b0;
    end else if (cfg.seq_load) begin
      seq_r <= cfg.seq_value;
    end else if (in_accept) begin
      seq_r   <= seq_nxt;
      pos_r   <= pos_nxt;
      chunk_r <= chunk_nxt;
      total_r <= e_total;
      hdr_r   <= e_hdr;
      ts_r    <= e_ts;
      frag_r  <= e_frag;
    end
  end

  assign desc_load = in_accept && active;

  always_comb begin
    desc.hdr_en   = hdr_en;
    desc.fu       = e_frag;
    desc.marker   = e_frag ? last_chunk : 1'b1;
    desc.seq      = seq_r;
    desc.ts       = e_ts;
    desc.ssrc     = cfg.ssrc;
    desc.fu_ind   = (e_hdr & NRI_MASK) | FU_A_TYPE;
    desc.fu_hdr   = (e_hdr & NAL_TYPE_MASK)
                  | ((e_pos == 16'd0) ? FU_START_BIT : 8'h00)
                  | (last_chunk ? FU_END_BIT : 8'h00);
    desc.pay_en   = pay_en;
    desc.pay_byte = in_data.data_byte;
    desc.pay_eop  = pay_eop;
  end

endmodule

[rtl/core/rtpfu_emit.sv]
// Byte sequencer and output register of the packetizer.
// Walks one descriptor through its header and payload bytes, one transfer per cycle unless stalled.
// Depends on rtpfu_pkg.
module rtpfu_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   desc_load,
  input  rtpfu_pkg::rtpfu_desc_t desc,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rtpfu_pkg::rtpfu_out_t  out_data
);
  import rtpfu_pkg::*;

  rtpfu_desc_t desc_r;
  logic        desc_valid_r;
  logic [3:0]  idx_r;
  logic        out_valid_r;
  rtpfu_out_t  out_r;

  logic [7:0]  hdr_b [0:15];
  logic [3:0]  hdr_len;
  logic [3:0]  n_res;
  logic        is_hdr;
  logic        last;
  logic        adv;
  rtpfu_out_t  out_nxt;

  always_comb begin
    hdr_b[0]  = RTP_VER_BYTE;
    hdr_b[1]  = desc_r.marker ? PT_MARKER : PT_NO_MARKER;
    hdr_b[2]  = desc_r.seq[15:8];
    hdr_b[3]  = desc_r.seq[7:0];
    hdr_b[4]  = desc_r.ts[31:24];
    hdr_b[5]  = desc_r.ts[23:16];
    hdr_b[6]  = desc_r.ts[15:8];
    hdr_b[7]  = desc_r.ts[7:0];
    hdr_b[8]  = desc_r.ssrc[31:24];
    hdr_b[9]  = desc_r.ssrc[23:16];
    hdr_b[10] = desc_r.ssrc[15:8];
    hdr_b[11] = desc_r.ssrc[7:0];
    hdr_b[12] = desc_r.fu_ind;
    hdr_b[13] = desc_r.fu_hdr;
    hdr_b[14] = 8'h00;
    hdr_b[15] = 8'h00;
  end

  assign hdr_len = desc_r.hdr_en ? (desc_r.fu ? FU_HDR_LEN : RTP_HDR_LEN) : 4'd0;
  assign n_res   = hdr_len + 4'(desc_r.pay_en);
  assign is_hdr  = idx_r < hdr_len;
  assign last    = idx_r == (n_res - 4'd1);

  // Header bytes never close a packet; only the payload byte can.
  assign out_nxt.out_byte      = is_hdr ? hdr_b[idx_r] : desc_r.pay_byte;
  assign out_nxt.end_of_packet = !is_hdr && desc_r.pay_eop;
  assign out_nxt.last_of_item  = last;

  assign adv      = desc_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !desc_valid_r || (adv && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (desc_load) begin
        desc_valid_r <= 1'b1;
        idx_r        <= '0;
      end else if (adv && last) begin
        desc_valid_r <= 1'b0;
      end else if (adv) begin
        idx_r <= idx_r + 4'd1;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_load) begin
      desc_r <= desc;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
